### sv/abag_pkg.sv
// Package for the array-based multiset table: sizes, operation codes,
// controller states and the command/status bundles between control and datapath.
// No dependencies.
package abag_pkg;

	localparam int CAPACITY   = 64;
	localparam int ITEM_WIDTH = 32;

	localparam int CMD_W   = 2;
	localparam int VALUE_W = 32;
	localparam int FIELD_W = 7;

	localparam int CNT_W  = $clog2(CAPACITY + 1);
	localparam int ADDR_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

	typedef enum logic [CMD_W-1:0] {
		OP_ADD    = 2'd0,
		OP_REMOVE = 2'd1,
		OP_LOOKUP = 2'd2,
		OP_CLEAR  = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_LAST_RD,
		ST_MOVE,
		ST_RESP
	} state_t;

	// controller -> datapath
	typedef struct packed {
		logic load;     // capture request, do add/clear update
		logic scan_rd;  // read at scan pointer, advance pointer
		logic last_rd;  // read the last live entry
		logic move_wr;  // move last entry into the matched slot
		logic finish;   // load the result register
	} ctrl_cmd_t;

	// datapath -> controller
	typedef struct packed {
		op_t  op;
		logic count_zero;
		logic scan_last;
		logic out_free;
	} dp_status_t;

endpackage

### sv/abag_if.sv
// Valid/ready channel interfaces for requests and results of the multiset table.
// Depends on abag_pkg.
interface abag_req_if import abag_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [CMD_W-1:0]   command;
	logic [VALUE_W-1:0] value;

	modport source (output valid, command, value, input ready);
	modport sink   (input valid, command, value, output ready);
endinterface

interface abag_rsp_if import abag_pkg::*; ();
	logic                      valid;
	logic                      ready;
	logic                      ok;
	logic signed [FIELD_W-1:0] first_index;
	logic        [FIELD_W-1:0] frequency;
	logic        [FIELD_W-1:0] entry_count;
	logic                      is_empty;

	modport source (output valid, ok, first_index, frequency, entry_count, is_empty,
		input ready);
	modport sink   (input valid, ok, first_index, frequency, entry_count, is_empty,
		output ready);
endinterface

### sv/abag_ctrl.sv
// Sequencer for the multiset table: accept, scan, remove-move, respond.
// Depends on abag_pkg.
module abag_ctrl import abag_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       req_valid,
	output logic       req_ready,
	input  dp_status_t status,
	output ctrl_cmd_t  cmd
);

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		req_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					cmd.load = 1'b1;
					// status.op is the incoming command while idle
					if ((status.op == OP_REMOVE || status.op == OP_LOOKUP) &&
						!status.count_zero) begin
						state_d = ST_SCAN;
					end else begin
						state_d = ST_RESP;
					end
				end
			end
			ST_SCAN: begin
				cmd.scan_rd = 1'b1;
				if (status.scan_last) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				// last compare lands this cycle
				state_d = (status.op == OP_REMOVE) ? ST_LAST_RD : ST_RESP;
			end
			ST_LAST_RD: begin
				cmd.last_rd = 1'b1;
				state_d     = ST_MOVE;
			end
			ST_MOVE: begin
				cmd.move_wr = 1'b1;
				state_d     = ST_RESP;
			end
			ST_RESP: begin
				if (status.out_free) begin
					cmd.finish = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

### sv/abag_dp.sv
// Datapath of the multiset table: entry memory, count, scan pointer, match
// tracking and the result register. Depends on abag_pkg.
module abag_dp import abag_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  ctrl_cmd_t                 cmd,
	output dp_status_t                status,
	input  logic [CMD_W-1:0]          command,
	input  logic [VALUE_W-1:0]        value,
	input  logic                      rsp_ready,
	output logic                      rsp_valid,
	output logic                      ok,
	output logic signed [FIELD_W-1:0] first_index,
	output logic [FIELD_W-1:0]        frequency,
	output logic [FIELD_W-1:0]        entry_count,
	output logic                      is_empty
);

	logic [ITEM_WIDTH-1:0] mem [CAPACITY];
	logic [ITEM_WIDTH-1:0] rd_data_q;
	logic [ITEM_WIDTH-1:0] val_q;
	op_t                   op_q;
	logic [CNT_W-1:0]      count_q;
	logic [ADDR_W-1:0]     scan_ptr_q;
	logic [ADDR_W-1:0]     idx_s1;
	logic                  cmp_vld_s1;
	logic                  found_q;
	logic [ADDR_W-1:0]     first_q;
	logic [CNT_W-1:0]      freq_q;
	logic                  ok_q;
	logic                  out_valid_q;

	logic                  full;
	logic [CNT_W-1:0]      count_m1;
	logic [ADDR_W-1:0]     rd_addr;
	logic                  rd_en;
	logic                  wr_en;
	logic [ADDR_W-1:0]     wr_addr;
	logic [ITEM_WIDTH-1:0] wr_data;
	logic                  match;
	logic                  add_ok;

	assign full     = (count_q == CNT_W'(CAPACITY));
	assign count_m1 = count_q - CNT_W'(1);
	assign match    = cmp_vld_s1 && (rd_data_q == val_q);
	assign add_ok   = (op_t'(command) == OP_ADD) && !full;

	// status: while a request is being accepted report the incoming command
	assign status.op         = cmd.load ? op_t'(command) : op_q;
	assign status.count_zero = (count_q == '0);
	assign status.scan_last  = ((CNT_W'(scan_ptr_q) + CNT_W'(1)) == count_q);
	assign status.out_free   = !out_valid_q || rsp_ready;

	assign rd_en   = cmd.scan_rd || cmd.last_rd;
	assign rd_addr = cmd.last_rd ? count_m1[ADDR_W-1:0] : scan_ptr_q;

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = count_q[ADDR_W-1:0];
		wr_data = ITEM_WIDTH'(value);
		if (cmd.load && add_ok) begin
			wr_en = 1'b1;
		end else if (cmd.move_wr && found_q) begin
			wr_en   = 1'b1;
			wr_addr = first_q;
			wr_data = rd_data_q;
		end
	end

	// single-port style memory: one write, one registered read
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q  <= op_t'(command);
			val_q <= ITEM_WIDTH'(value);
			ok_q  <= add_ok || (op_t'(command) == OP_CLEAR);
		end
		idx_s1 <= scan_ptr_q;
		if (match && !found_q) begin
			first_q <= idx_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			scan_ptr_q  <= '0;
			cmp_vld_s1  <= 1'b0;
			found_q     <= 1'b0;
			freq_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			cmp_vld_s1 <= cmd.scan_rd;
			if (cmd.load) begin
				scan_ptr_q <= '0;
				found_q    <= 1'b0;
				freq_q     <= '0;
				if (add_ok) begin
					count_q <= count_q + CNT_W'(1);
				end else if (op_t'(command) == OP_CLEAR) begin
					count_q <= '0;
				end
			end else begin
				if (cmd.scan_rd) begin
					scan_ptr_q <= scan_ptr_q + ADDR_W'(1);
				end
				if (match) begin
					found_q <= 1'b1;
					freq_q  <= freq_q + CNT_W'(1);
				end
				if (cmd.move_wr && found_q) begin
					count_q <= count_m1;
				end
			end
			if (cmd.finish) begin
				out_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			case (op_q)
				OP_ADD, OP_CLEAR: begin
					ok          <= ok_q;
					first_index <= '1;
					frequency   <= '0;
				end
				OP_REMOVE: begin
					ok          <= found_q;
					first_index <= found_q ? FIELD_W'(first_q) : '1;
					frequency   <= '0;
				end
				default: begin
					ok          <= found_q;
					first_index <= found_q ? FIELD_W'(first_q) : '1;
					frequency   <= found_q ? FIELD_W'(freq_q) : '0;
				end
			endcase
			entry_count <= FIELD_W'(count_q);
			is_empty    <= (count_q == '0);
		end
	end

	assign rsp_valid = out_valid_q;

endmodule

### sv/array_bag_multiset_table.sv
// Array-based multiset table: add, remove (swap-with-last), lookup, clear.
// Add and clear need no scan; lookup and remove scan the live entries one per
// cycle (no scan when empty), and remove then reads the last entry and, on a
// match, moves it into the first matched slot. One request in flight at a time.
// A new request is taken while the previous result still waits on the output.
// Reset (arst_n low) empties the count; stored values stay undefined until written.
module array_bag_multiset_table import abag_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	abag_req_if.sink   req,
	abag_rsp_if.source rsp
);

	ctrl_cmd_t  cmd;
	dp_status_t status;

	// Control: idle -> (scan -> drain -> [last read -> move]) -> respond.
	abag_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.status    (status),
		.cmd       (cmd)
	);

	// Datapath: memory is scanned one entry per cycle with a registered read;
	// the compare stage acts in the cycle after the read, so the drain state
	// catches the last entry's compare before any remove decision.
	abag_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.status      (status),
		.command     (req.command),
		.value       (req.value),
		.rsp_ready   (rsp.ready),
		.rsp_valid   (rsp.valid),
		.ok          (rsp.ok),
		.first_index (rsp.first_index),
		.frequency   (rsp.frequency),
		.entry_count (rsp.entry_count),
		.is_empty    (rsp.is_empty)
	);

endmodule
